@@ hw/rtl/sil_pkg.sv @@
package sil_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    localparam int DAY_W  = 7;
    localparam int REF_W  = 16;
    localparam int STAT_W = 3;

    localparam logic [DAY_W-1:0] DAY_MIN = 7'd1;
    localparam logic [DAY_W-1:0] DAY_MAX = 7'd99;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LIST   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_DAY  = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    ins;         // commit the held insert
        logic    list_start;  // clear the list walk index
        logic    rot;         // rotate the valid cells by one place
        logic    emit;        // load the output register
        logic    emit_entry;  // take day and ref from the head cell
        logic    emit_last;
        t_status emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic day_ok;
        logic rot_last;
    } t_stat;

endpackage

@@ hw/rtl/sorted_insert_list.sv @@
// Sorted list of up to LIST_DEPTH reminder entries kept in ascending day order; an insert
// lands after every entry with an equal or smaller day, so equal days keep arrival order.
// tuser on the input picks the operation (0 insert, 1 list). An insert answers with one
// word: inserted, full, or bad day (day outside 1..99; full is checked first). A list
// streams every entry as one word per cycle while the output is not stalled, head first,
// with tlast on the final one; accepting the request only starts the walk. The cell row
// rotates by one place per word to bring each entry to the head, and no input is taken
// until the walk ends. An empty list answers with one word.
// A stalled output word is held in its register and holds off the next input or word.
module sorted_insert_list #(
    parameter int LIST_DEPTH = sil_pkg::LIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // day[6:0], reminder_ref[22:7], zero pad
    input  logic        i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_day[6:0], out_ref[22:7], zero pad
    output logic [2:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast
);

    sil_pkg::t_cmd  w_cmd;
    sil_pkg::t_stat w_stat;

    logic [sil_pkg::DAY_W-1:0] w_out_day;
    logic [sil_pkg::REF_W-1:0] w_out_ref;

    sil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sil_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_day        (i_s_axis_tdata[6:0]),
        .i_ref        (i_s_axis_tdata[22:7]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (o_m_axis_tuser),
        .o_out_day    (w_out_day),
        .o_out_ref    (w_out_ref),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_out_ref, w_out_day};

endmodule

@@ hw/rtl/sil_ctrl.sv @@
module sil_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    output logic           o_in_ready,
    input  sil_pkg::t_stat i_stat,
    output sil_pkg::t_cmd  o_cmd
);

    sil_pkg::t_state r_state;
    sil_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sil_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.ins         = 1'b0;
        o_cmd.list_start  = 1'b0;
        o_cmd.rot         = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.emit_entry  = 1'b0;
        o_cmd.emit_last   = 1'b0;
        o_cmd.emit_status = sil_pkg::ST_INSERTED;
        case (r_state)
            sil_pkg::S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_in_op == sil_pkg::OP_LIST) begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = sil_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.list_start = 1'b1;
                            n_state          = sil_pkg::S_LIST;
                        end
                    end else begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        // full check wins over the day check
                        if (i_stat.full) begin
                            o_cmd.emit_status = sil_pkg::ST_FULL;
                        end else if (!i_stat.day_ok) begin
                            o_cmd.emit_status = sil_pkg::ST_BAD_DAY;
                        end else begin
                            o_cmd.ins         = 1'b1;
                            o_cmd.emit_status = sil_pkg::ST_INSERTED;
                        end
                    end
                end
            end
            sil_pkg::S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_entry  = 1'b1;
                    o_cmd.rot         = 1'b1;
                    o_cmd.emit_last   = i_stat.rot_last;
                    o_cmd.emit_status = sil_pkg::ST_ENTRY;
                    if (i_stat.rot_last) begin
                        n_state = sil_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sil_pkg::S_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sil_pkg::S_LIST) |-> !o_in_ready)
        else $error("input taken during list walk");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rot || o_cmd.ins) |-> i_stat.out_free)
        else $error("list change without a free output slot");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.list_start |-> !i_stat.empty)
        else $error("list walk started on an empty list");

endmodule

@@ hw/rtl/sil_datapath.sv @@
module sil_datapath #(
    parameter int LIST_DEPTH = sil_pkg::LIST_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sil_pkg::DAY_W-1:0]    i_day,
    input  logic [sil_pkg::REF_W-1:0]    i_ref,
    input  sil_pkg::t_cmd                i_cmd,
    output sil_pkg::t_stat               o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [sil_pkg::STAT_W-1:0]   o_out_status,
    output logic [sil_pkg::DAY_W-1:0]    o_out_day,
    output logic [sil_pkg::REF_W-1:0]    o_out_ref,
    output logic                         o_out_last
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    logic [sil_pkg::DAY_W-1:0] r_day [LIST_DEPTH];
    logic [sil_pkg::REF_W-1:0] r_ref [LIST_DEPTH];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic [LIST_DEPTH-1:0]     w_ins;
    logic [CW-1:0]             w_tail;

    logic                        r_out_valid;
    sil_pkg::t_status            r_out_status;
    logic [sil_pkg::DAY_W-1:0]   r_out_day;
    logic [sil_pkg::REF_W-1:0]   r_out_ref;
    logic                        r_out_last;

    assign w_tail = r_count - CW'(1);

    // one row of cells; an insert shifts every cell at or past the slot
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);

        // monotonic along the row, cells past the count always qualify
        assign w_ins[g] = (IDX >= r_count) || (i_day < r_day[g]);

        always_ff @(posedge i_clk) begin
            if (i_cmd.ins && w_ins[g]) begin
                if (g == 0) begin
                    r_day[g] <= i_day;
                    r_ref[g] <= i_ref;
                end else if (!w_ins[(g == 0) ? 0 : g - 1]) begin
                    r_day[g] <= i_day;
                    r_ref[g] <= i_ref;
                end else begin
                    r_day[g] <= r_day[(g == 0) ? 0 : g - 1];
                    r_ref[g] <= r_ref[(g == 0) ? 0 : g - 1];
                end
            end else if (i_cmd.rot && (IDX <= w_tail)) begin
                // rotate the valid part so the head walks through every entry
                if (IDX == w_tail) begin
                    r_day[g] <= r_day[0];
                    r_ref[g] <= r_ref[0];
                end else begin
                    r_day[g] <= r_day[(g == LIST_DEPTH - 1) ? g : g + 1];
                    r_ref[g] <= r_ref[(g == LIST_DEPTH - 1) ? g : g + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.ins) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.list_start) begin
                r_idx <= '0;
            end else if (i_cmd.rot) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_last   <= i_cmd.emit_last;
            r_out_day    <= i_cmd.emit_entry ? r_day[0] : '0;
            r_out_ref    <= i_cmd.emit_entry ? r_ref[0] : '0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count >= DEPTH_C);
    assign o_stat.day_ok   = (i_day >= sil_pkg::DAY_MIN) && (i_day <= sil_pkg::DAY_MAX);
    assign o_stat.rot_last = (r_idx == w_tail);

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_day    = r_out_day;
    assign o_out_ref    = r_out_ref;
    assign o_out_last   = r_out_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count past list depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not bump the count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ins |=> $stable(r_count))
        else $error("count moved without an insert");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rot |-> (r_idx < r_count))
        else $error("list walk ran past the last entry");

endmodule

@@ test/sorted_insert_list_chk.sv @@
`timescale 1ns / 100ps

module sorted_insert_list_chk #(
    parameter int DEPTH = sil_pkg::LIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [23:0] i_in_tdata,    // day[6:0], reminder_ref[22:7], zero pad
    input  logic        i_in_tuser,    // operation
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [23:0] i_out_tdata,   // out_day[6:0], out_ref[22:7], zero pad
    input  logic [2:0]  i_out_tuser,   // status
    input  logic        i_out_tlast,
    output int          o_fail_cnt,
    output int          o_pending
);

    typedef struct packed {
        sil_pkg::t_status          status;
        logic [sil_pkg::DAY_W-1:0] day;
        logic [sil_pkg::REF_W-1:0] rref;
        logic                      last;
    } t_reply;

    t_reply                    reply_q[$];
    logic [sil_pkg::DAY_W-1:0] cell_day [DEPTH];
    logic [sil_pkg::REF_W-1:0] cell_ref [DEPTH];
    int                        cell_cnt = 0;

    function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            o_fail_cnt++;
        end
    endfunction

    // sorted list with stable placement of equal days
    function automatic void predict_replies(logic op, logic [sil_pkg::DAY_W-1:0] day,
                                            logic [sil_pkg::REF_W-1:0] rref);
        int pos;
        if (op == sil_pkg::OP_LIST) begin
            if (cell_cnt == 0)
                reply_q.push_back('{sil_pkg::ST_EMPTY, '0, '0, 1'b1});
            else
                for (int i = 0; i < cell_cnt; i++)
                    reply_q.push_back('{sil_pkg::ST_ENTRY, cell_day[i], cell_ref[i],
                                        i == cell_cnt - 1});
        end else if (cell_cnt >= DEPTH) begin
            reply_q.push_back('{sil_pkg::ST_FULL, '0, '0, 1'b1});
        end else if (day < sil_pkg::DAY_MIN || day > sil_pkg::DAY_MAX) begin
            reply_q.push_back('{sil_pkg::ST_BAD_DAY, '0, '0, 1'b1});
        end else begin
            pos = cell_cnt;
            for (int i = cell_cnt - 1; i >= 0; i--)
                if (day < cell_day[i])
                    pos = i;
            for (int i = cell_cnt; i > pos; i--) begin
                cell_day[i] = cell_day[i-1];
                cell_ref[i] = cell_ref[i-1];
            end
            cell_day[pos] = day;
            cell_ref[pos] = rref;
            cell_cnt++;
            reply_q.push_back('{sil_pkg::ST_INSERTED, '0, '0, 1'b1});
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            cell_cnt = 0;
            reply_q.delete();
        end else begin
            if (i_in_tvalid === 1'b1 && i_in_tready === 1'b1)
                predict_replies(i_in_tuser, i_in_tdata[sil_pkg::DAY_W-1:0],
                                i_in_tdata[sil_pkg::DAY_W+sil_pkg::REF_W-1:sil_pkg::DAY_W]);
            if (i_out_tvalid === 1'b1 && i_out_tready === 1'b1) begin
                if (reply_q.size() == 0) begin
                    $error("word with nothing expected: status %0d", i_out_tuser);
                    o_fail_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 16'(want.status), 16'(i_out_tuser));
                    check_field("out_day", 16'(want.day),
                                16'(i_out_tdata[sil_pkg::DAY_W-1:0]));
                    check_field("out_ref", want.rref,
                                i_out_tdata[sil_pkg::DAY_W+sil_pkg::REF_W-1:sil_pkg::DAY_W]);
                    check_field("last", 16'(want.last), 16'(i_out_tlast));
                end
            end
        end
        o_pending = reply_q.size();
    end

endmodule

@@ test/sorted_insert_list_tb.sv @@
`timescale 1ns / 100ps

module sorted_insert_list_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN       = 32;
    localparam int N_RANDOM    = 180;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [23:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = sil_pkg::OP_INSERT;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    int fail_cnt;
    int pending;
    int idle_cycles = 0;
    bit in_calm     = 1'b0;
    bit out_calm    = 1'b0;

    sorted_insert_list u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    sorted_insert_list_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (i_s_axis_tvalid),
        .i_in_tready  (o_s_axis_tready),
        .i_in_tdata   (i_s_axis_tdata),
        .i_in_tuser   (i_s_axis_tuser),
        .i_out_tvalid (o_m_axis_tvalid),
        .i_out_tready (i_m_axis_tready),
        .i_out_tdata  (o_m_axis_tdata),
        .i_out_tuser  (o_m_axis_tuser),
        .i_out_tlast  (o_m_axis_tlast),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready === 1'b1)
                || (o_m_axis_tvalid === 1'b1 && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_request(input logic op, input logic [sil_pkg::DAY_W-1:0] day,
                                input logic [sil_pkg::REF_W-1:0] rref);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {1'b0, rref, day};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    // receiver side
    initial begin
        int gap;
        int words;
        words = 0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (words % 40 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            gap = out_calm ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
            words++;
        end
    end

    initial begin
        int pick;
        logic op;
        logic [sil_pkg::DAY_W-1:0] day;
        logic [sil_pkg::REF_W-1:0] rref;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_request(sil_pkg::OP_LIST, 7'd0, 16'h0000);        // empty list
        push_request(sil_pkg::OP_INSERT, 7'd0, 16'hffff);      // day below range
        push_request(sil_pkg::OP_INSERT, 7'd100, 16'h1234);    // day just above range
        push_request(sil_pkg::OP_INSERT, 7'd127, 16'h0000);
        push_request(sil_pkg::OP_INSERT, sil_pkg::DAY_MAX, 16'h0000);
        push_request(sil_pkg::OP_INSERT, sil_pkg::DAY_MIN, 16'hffff);   // new head
        push_request(sil_pkg::OP_INSERT, 7'd50, 16'h1234);
        push_request(sil_pkg::OP_INSERT, 7'd50, 16'h5678);     // equal day goes after
        push_request(sil_pkg::OP_INSERT, sil_pkg::DAY_MIN, 16'haaaa);
        push_request(sil_pkg::OP_INSERT, 7'd98, 16'h5555);
        push_request(sil_pkg::OP_LIST, 7'd0, 16'h0000);
        push_request(sil_pkg::OP_LIST, 7'd127, 16'hffff);      // list ignores day and ref

        // there is no delete, so the list fills during this part and the
        // rest of it works on full rejects and long lists
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 20 == 0)
                in_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            op   = sil_pkg::OP_INSERT;
            rref = 16'($urandom_range(0, 65535));
            if (pick < 25) begin
                op  = sil_pkg::OP_LIST;
                day = 7'($urandom_range(0, 127));
            end else if (pick < 40) begin
                day = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(100, 127));
            end else if (pick < 70) begin
                day = 7'($urandom_range(1, 8));           // many equal days
            end else begin
                day = 7'($urandom_range(sil_pkg::DAY_MIN, sil_pkg::DAY_MAX));
            end
            push_request(op, day, rref);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sil_pkg.sv
hw/rtl/sil_ctrl.sv
hw/rtl/sil_datapath.sv
hw/rtl/sorted_insert_list.sv
test/sorted_insert_list_chk.sv
test/sorted_insert_list_tb.sv
